>>> rtl/fixed_point_square_root_core_assert.svh
// Assertion macros for the RTL files that check their own logic.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef FIXED_POINT_SQUARE_ROOT_CORE_ASSERT_SVH
`define FIXED_POINT_SQUARE_ROOT_CORE_ASSERT_SVH

// The expression holds at every clock edge out of reset.
`define FPSR_ASSERT_ALWAYS(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define FPSR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// The consequent holds in the cycle after the antecedent.
`define FPSR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

>>> rtl/fpsr_pkg.sv
package fpsr_pkg;

	// Default width of the signed radicand.
	localparam int INPUT_BITS_DEF = 32;

	// Scale factor applied before the root: 1000 squared.
	localparam int MILLI_SQ_BITS = 20;
	localparam logic [MILLI_SQ_BITS-1:0] MILLI_SQ = 20'd1000000;

	// Width of the result; wider roots saturate.
	localparam int OUT_BITS = 26;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_ROOT,
		ST_EMIT
	} fpsr_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic sum;
		logic step;
		logic emit;
	} fpsr_cmd_t;

endpackage

>>> rtl/fpsr_dp.sv
module fpsr_dp #(
	parameter int INPUT_BITS = fpsr_pkg::INPUT_BITS_DEF
) (
	input  logic                                clk,
	input  logic signed [INPUT_BITS-1:0]        radicand,
	input  fpsr_pkg::fpsr_cmd_t                 cmd,
	output logic [fpsr_pkg::OUT_BITS-1:0]       root_milli
);

	localparam int K_BITS       = fpsr_pkg::MILLI_SQ_BITS;
	localparam int MAG_BITS     = INPUT_BITS - 1;
	localparam int LO_BITS      = (MAG_BITS + 1) / 2;
	localparam int HI_BITS      = MAG_BITS - LO_BITS;
	localparam int LO_PROD_BITS = LO_BITS + K_BITS;
	localparam int HI_PROD_BITS = HI_BITS + K_BITS;
	localparam int PROD_BITS    = MAG_BITS + K_BITS;
	localparam int ROOT_BITS    = (PROD_BITS + 1) / 2;
	localparam int RAD_BITS     = 2 * ROOT_BITS;
	localparam int REM_BITS     = ROOT_BITS + 1;
	localparam int OB           = fpsr_pkg::OUT_BITS;

	logic [MAG_BITS-1:0]     mag;
	logic [LO_PROD_BITS-1:0] lo_prod_s1;
	logic [HI_PROD_BITS-1:0] hi_prod_s1;
	logic [RAD_BITS-1:0]     rad_q;
	logic [REM_BITS-1:0]     rem_q;
	logic [ROOT_BITS-1:0]    root_q;
	logic [REM_BITS+1:0]     rem_shift;
	logic [REM_BITS+1:0]     trial;
	logic [REM_BITS+1:0]     rem_diff;
	logic                    take;
	logic [OB-1:0]           root_sat;
	logic [OB-1:0]           root_milli_q;

	// Zero and negative radicands both reduce to a zero magnitude.
	assign mag = radicand[INPUT_BITS-1] ? '0 : MAG_BITS'($unsigned(radicand));

	// Scale by one million as two half-width products, registered.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_prod_s1 <= LO_PROD_BITS'(mag[LO_BITS-1:0]) * LO_PROD_BITS'(fpsr_pkg::MILLI_SQ);
			hi_prod_s1 <= HI_PROD_BITS'(mag[MAG_BITS-1:LO_BITS])
				* HI_PROD_BITS'(fpsr_pkg::MILLI_SQ);
		end
	end

	// One root bit per step: bring down two radicand bits, try (4*root+1).
	assign rem_shift = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign trial     = {1'b0, root_q, 2'b01};
	assign rem_diff  = rem_shift - trial;
	assign take      = (rem_shift >= trial);

	// Radicand, partial remainder and root registers.
	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			rad_q  <= (RAD_BITS'(hi_prod_s1) << LO_BITS) + RAD_BITS'(lo_prod_s1);
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.step) begin
			rad_q  <= rad_q << 2;
			rem_q  <= take ? rem_diff[REM_BITS-1:0] : rem_shift[REM_BITS-1:0];
			root_q <= {root_q[ROOT_BITS-2:0], take};
		end
	end

	// Fit the root to the output width, saturating when it is wider.
	generate
		if (ROOT_BITS > OB) begin : g_sat
			assign root_sat = (|root_q[ROOT_BITS-1:OB]) ? '1 : root_q[OB-1:0];
		end else begin : g_ext
			assign root_sat = OB'(root_q);
		end
	endgenerate

	// Output register, loaded when the result is handed to the output slot.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			root_milli_q <= root_sat;
		end
	end

	assign root_milli = root_milli_q;

endmodule

>>> rtl/fpsr_ctrl.sv
module fpsr_ctrl #(
	parameter int ROOT_BITS = (fpsr_pkg::INPUT_BITS_DEF + fpsr_pkg::MILLI_SQ_BITS) / 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                radicand_valid,
	output logic                radicand_ready,
	output logic                root_valid,
	input  logic                root_ready,
	output fpsr_pkg::fpsr_cmd_t cmd
);

	localparam int CNT_BITS = (ROOT_BITS > 1) ? $clog2(ROOT_BITS) : 1;
	localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(ROOT_BITS - 1);

	fpsr_pkg::fpsr_state_t state_q, state_d;
	logic [CNT_BITS-1:0]   cnt_q, cnt_d;
	logic                  out_valid_q, out_valid_d;

	// State, step counter and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fpsr_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d        = state_q;
		cnt_d          = cnt_q;
		cmd            = '0;
		radicand_ready = 1'b0;
		case (state_q)
			fpsr_pkg::ST_IDLE: begin
				radicand_ready = 1'b1;
				if (radicand_valid) begin
					cmd.load = 1'b1;
					state_d  = fpsr_pkg::ST_MUL;
				end
			end
			fpsr_pkg::ST_MUL: begin
				cmd.sum = 1'b1;
				cnt_d   = '0;
				state_d = fpsr_pkg::ST_ROOT;
			end
			fpsr_pkg::ST_ROOT: begin
				cmd.step = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					state_d = fpsr_pkg::ST_EMIT;
				end
			end
			fpsr_pkg::ST_EMIT: begin
				// Wait until the output slot is empty or being emptied.
				if (!out_valid_q || root_ready) begin
					cmd.emit = 1'b1;
					state_d  = fpsr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fpsr_pkg::ST_IDLE;
			end
		endcase
	end

	// The output slot fills on emit and drains on a transfer.
	always_comb begin
		if (cmd.emit) begin
			out_valid_d = 1'b1;
		end else if (root_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	assign root_valid = out_valid_q;

endmodule

>>> rtl/fixed_point_square_root_core.sv
// Fixed-point square root: for each signed radicand the core returns
// root_milli = floor(sqrt(radicand * 1000000)), the root with three decimal digits;
// zero and negative radicands give zero, and a root wider than 26 bits (possible
// only with INPUT_BITS above 32) saturates at all ones. One item is in flight at a
// time: after a radicand is taken the core runs the scaling multiply, the partial
// product sum, the digit-by-digit root recurrence, which settles one root bit per
// cycle, and the load of the output register before it takes the next radicand;
// the recurrence yields ROOT_BITS = (INPUT_BITS + 20) / 2 root bits, 26 by default.
// The output register lets the core take the next radicand while a result still
// waits to be transferred out; the load of a new result waits until that one goes.
`include "fixed_point_square_root_core_assert.svh"

module fixed_point_square_root_core #(
	parameter int INPUT_BITS = fpsr_pkg::INPUT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          radicand_valid,
	output logic                          radicand_ready,
	input  logic signed [INPUT_BITS-1:0]  radicand,
	output logic                          root_valid,
	input  logic                          root_ready,
	output logic [fpsr_pkg::OUT_BITS-1:0] root_milli
);

	localparam int ROOT_BITS = (INPUT_BITS + fpsr_pkg::MILLI_SQ_BITS) / 2;

	fpsr_pkg::fpsr_cmd_t cmd;

	// Sequencer: handshakes and step counting.
	fpsr_ctrl #(
		.ROOT_BITS (ROOT_BITS)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.radicand_valid (radicand_valid),
		.radicand_ready (radicand_ready),
		.root_valid     (root_valid),
		.root_ready     (root_ready),
		.cmd            (cmd)
	);

	// Scaling multiply, root recurrence and output register.
	fpsr_dp #(
		.INPUT_BITS (INPUT_BITS)
	) u_dp (
		.clk        (clk),
		.radicand   (radicand),
		.cmd        (cmd),
		.root_milli (root_milli)
	);

	// At most one datapath command is issued per cycle.
	`FPSR_ASSERT_ALWAYS(a_cmd_onehot, $onehot0({cmd.load, cmd.sum, cmd.step, cmd.emit}))
	// A new result is never written over one that has not been transferred.
	`FPSR_ASSERT_IMPL(a_no_overwrite, cmd.emit, !root_valid || root_ready)
	// After a radicand is taken the core is busy in the next cycle.
	`FPSR_ASSERT_NEXT(a_busy_after_take, radicand_valid && radicand_ready, !radicand_ready)

endmodule
